[src/scft_pkg.sv]
package scft_pkg;

  // coordinate and result widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 15;

  // squared distance, root and deviation widths
  localparam int unsigned D2W     = 34;
  localparam int unsigned RootW   = D2W / 2;
  localparam int unsigned MulW    = 18;
  localparam int unsigned SumW    = 48;

  // default store capacity
  localparam int unsigned MaxPointsDef = 1024;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegXOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] RegYOffset = 2'd1;

endpackage

[src/scft_isqrt.sv]
module scft_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scft_pkg::D2W-1:0]     radicand_i,
  output logic                         done_o,
  output logic [scft_pkg::RootW-1:0]   root_o
);

  localparam int unsigned W = scft_pkg::D2W;

  logic           run_q, run_d;
  logic           done_q, done_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [W-1:0]   res_q, res_d;
  logic [W-1:0]   bit_q, bit_d;
  logic [W:0]     trial;

  // one result digit per cycle, from the top pair of bits down
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    if (start_i) begin
      run_d = 1'b1;
      rem_d = radicand_i;
      res_d = '0;
      bit_d = W'(1) << (W - 2);
    end else if (run_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[scft_pkg::RootW-1:0];

endmodule

[src/stroke_circle_fit_test.sv]
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------------------
// point     | in        | start_i high, busy_o low  | point_x_i, point_y_i, last_point_i
// result    | out       | done_o, one-cycle strobe  | is_circle_o, mid_x_o, mid_y_o,
//           |           |                           | circle_radius_o, overflowed_o
// config    | in        | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i
//
// A point that is not last does not make the block busy, so a new one can follow at once.
// A last point starts the walk, which takes each stored point in turn through the
// 17-step shared root unit and the single shared 18x18 multiplier; busy_o is high then.
// The result strobe comes in the cycle after the walk ends; the receiver cannot stall it.
// Reset clears the offsets, the point count, the box and the sequencer; store contents
// are not cleared, since only written entries are ever read.
module stroke_circle_fit_test #(
  parameter int unsigned MAX_POINTS = scft_pkg::MaxPointsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [scft_pkg::CoordW-1:0] point_x_i,
  input  logic signed [scft_pkg::CoordW-1:0] point_y_i,
  input  logic                               last_point_i,
  output logic                               done_o,
  output logic                               is_circle_o,
  output logic signed [scft_pkg::CoordW-1:0] mid_x_o,
  output logic signed [scft_pkg::CoordW-1:0] mid_y_o,
  output logic [scft_pkg::RadiusW-1:0]       circle_radius_o,
  output logic                               overflowed_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [scft_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [scft_pkg::CoordW-1:0]        cfg_data_i
);

  localparam int unsigned CW    = scft_pkg::CoordW;
  localparam int unsigned RW    = scft_pkg::RadiusW;
  localparam int unsigned D2W   = scft_pkg::D2W;
  localparam int unsigned RootW = scft_pkg::RootW;
  localparam int unsigned MulW  = scft_pkg::MulW;
  localparam int unsigned SumW  = scft_pkg::SumW;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IdxW  = $clog2(MAX_POINTS);

  // sequencer codes
  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StCenter = 4'd1;
  localparam logic [3:0] StRead   = 4'd2;
  localparam logic [3:0] StSqx    = 4'd3;
  localparam logic [3:0] StSqy    = 4'd4;
  localparam logic [3:0] StAdd    = 4'd5;
  localparam logic [3:0] StRoot   = 4'd6;
  localparam logic [3:0] StDev    = 4'd7;
  localparam logic [3:0] StAcc    = 4'd8;
  localparam logic [3:0] StRsq    = 4'd9;
  localparam logic [3:0] StCmp    = 4'd10;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      sat_add = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      sat_add = s[CW-1:0];
    end
  endfunction

  logic [3:0]              state_q, state_d;
  logic signed [CW-1:0]    x_off_q, y_off_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    drop_q, drop_d;
  logic signed [CW-1:0]    min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [CW-1:0]    min_x_d, max_x_d, min_y_d, max_y_d;
  logic signed [CW-1:0]    cx_q, cy_q;
  logic [RW-1:0]           r_q;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [D2W-1:0]          d2_q, d2_d;
  logic [D2W-1:0]          prod_q;
  logic [SumW-1:0]         sum_q, sum_d;
  logic                    done_q;
  logic                    res_circle_q;
  logic signed [CW-1:0]    res_cx_q, res_cy_q;
  logic [RW-1:0]           res_r_q;
  logic                    res_ovf_q;

  logic                    accept;
  logic                    full;
  logic signed [CW-1:0]    px, py;
  logic signed [CW-1:0]    rd_x_q, rd_y_q;
  logic signed [CW-1:0]    mem_x [MAX_POINTS];
  logic signed [CW-1:0]    mem_y [MAX_POINTS];

  logic signed [MulW-1:0]  mul_a;
  logic signed [2*MulW-1:0] mul_p;
  logic signed [CW:0]      sum_cx, sum_cy;
  logic [CW:0]             wid, hgt;
  logic [CW+1:0]           wh;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [RootW-1:0]        root;
  logic [SumW:0]           acc_ext;

  assign accept      = start_i && (state_q == StLoad);
  assign full        = (cnt_q == CntW'(MAX_POINTS));
  assign px          = sat_add(point_x_i, x_off_q);
  assign py          = sat_add(point_y_i, y_off_q);
  assign busy_o      = (state_q != StLoad);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= '0;
      y_off_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        scft_pkg::RegXOffset: x_off_q <= cfg_data_i;
        scft_pkg::RegYOffset: y_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // point store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      mem_x[cnt_q[IdxW-1:0]] <= px;
      mem_y[cnt_q[IdxW-1:0]] <= py;
    end
    if (state_q == StRead) begin
      rd_x_q <= mem_x[idx_q];
      rd_y_q <= mem_y[idx_q];
    end
  end

  // shared multiplier operand select, both operands the same value
  always_comb begin
    case (state_q)
      StSqx:   mul_a = MulW'(rd_x_q) - MulW'(cx_q);
      StSqy:   mul_a = MulW'(rd_y_q) - MulW'(cy_q);
      StDev:   mul_a = MulW'(root) - MulW'(r_q);
      StRsq:   mul_a = MulW'(r_q);
      default: mul_a = '0;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[D2W-1:0];
  end

  // box midpoint and quarter extent
  assign sum_cx = {min_x_q[CW-1], min_x_q} + {max_x_q[CW-1], max_x_q};
  assign sum_cy = {min_y_q[CW-1], min_y_q} + {max_y_q[CW-1], max_y_q};
  assign wid    = (CW+1)'(max_x_q) - (CW+1)'(min_x_q);
  assign hgt    = (CW+1)'(max_y_q) - (CW+1)'(min_y_q);
  assign wh     = {1'b0, wid} + {1'b0, hgt};

  assign sqrt_start = (state_q == StAdd);
  assign acc_ext    = {1'b0, sum_q} + (SumW+1)'(prod_q);

  scft_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (d2_d),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // sequencer and stroke state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    idx_d   = idx_q;
    d2_d    = d2_q;
    sum_d   = sum_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == '0) begin
              min_x_d = px;
              max_x_d = px;
              min_y_d = py;
              max_y_d = py;
            end else begin
              if (px < min_x_q) min_x_d = px;
              if (px > max_x_q) max_x_d = px;
              if (py < min_y_q) min_y_d = py;
              if (py > max_y_q) max_y_d = py;
            end
          end
          if (last_point_i) begin
            state_d = StCenter;
          end
        end
      end
      StCenter: begin
        idx_d   = '0;
        sum_d   = '0;
        state_d = StRead;
      end
      StRead: state_d = StSqx;
      StSqx:  state_d = StSqy;
      StSqy: begin
        d2_d    = prod_q;
        state_d = StAdd;
      end
      StAdd: begin
        d2_d    = d2_q + prod_q;
        state_d = StRoot;
      end
      StRoot: begin
        if (sqrt_done) begin
          state_d = StDev;
        end
      end
      StDev: state_d = StAcc;
      StAcc: begin
        sum_d = acc_ext[SumW] ? {SumW{1'b1}} : acc_ext[SumW-1:0];
        if (CntW'(idx_q) + CntW'(1) == cnt_q) begin
          state_d = StRsq;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = StRead;
        end
      end
      StRsq: state_d = StCmp;
      StCmp: begin
        cnt_d   = '0;
        drop_d  = 1'b0;
        min_x_d = '0;
        max_x_d = '0;
        min_y_d = '0;
        max_y_d = '0;
        sum_d   = '0;
        state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
      sum_q   <= sum_d;
      done_q  <= (state_q == StCmp);
    end
  end

  // walk datapath and result registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    d2_q  <= d2_d;
    if (state_q == StCenter) begin
      cx_q <= sum_cx[CW:1];
      cy_q <= sum_cy[CW:1];
      r_q  <= wh[RW+1:2];
    end
    if (state_q == StCmp) begin
      res_circle_q <= (r_q != '0) && (sum_q < SumW'(prod_q));
      res_cx_q     <= cx_q;
      res_cy_q     <= cy_q;
      res_r_q      <= r_q;
      res_ovf_q    <= drop_q;
    end
  end

  assign done_o          = done_q;
  assign is_circle_o     = res_circle_q;
  assign mid_x_o         = res_cx_q;
  assign mid_y_o         = res_cy_q;
  assign circle_radius_o = res_r_q;
  assign overflowed_o    = res_ovf_q;

endmodule

[src/scft_sva.sv]
module scft_sva (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         last_point_i,
  input logic                         done_o,
  input logic                         is_circle_o,
  input logic [scft_pkg::RadiusW-1:0] circle_radius_o
);

  // a result only ends a walk
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) && !busy_o)
    else $error("result strobe without a preceding walk");

  // an inner point keeps the block ready
  a_inner_point_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_point_i) |=> !busy_o)
    else $error("block went busy on an inner point");

  // the last point starts the walk
  a_last_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_point_i) |=> busy_o && !done_o)
    else $error("last point did not start the walk");

  // a zero radius never passes
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_circle_o) |-> (circle_radius_o != '0))
    else $error("circle reported with zero radius");

endmodule

bind stroke_circle_fit_test scft_sva u_scft_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .last_point_i    (last_point_i),
  .done_o          (done_o),
  .is_circle_o     (is_circle_o),
  .circle_radius_o (circle_radius_o)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import scft_pkg::*;

  localparam int unsigned Cap = MaxPointsDef;
  localparam int CoordMax = (1 << (CoordW - 1)) - 1;
  localparam int CoordMin = -(1 << (CoordW - 1));
  localparam longint unsigned DevSumMax = (64'd1 << SumW) - 1;
  localparam int SettleCycles = 32;
  localparam int PhaseItems = 105;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic                     is_circle;
    logic signed [CoordW-1:0] mid_x;
    logic signed [CoordW-1:0] mid_y;
    logic [RadiusW-1:0]       radius;
    logic                     overflowed;
  } circle_fit_t;

  typedef enum int {ShapeCircle, ShapeNoise, ShapeLine, ShapePoint} shape_e;

  // dut ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic                     last_point_i = 1'b0;
  logic                     done_o;
  logic                     is_circle_o;
  logic signed [CoordW-1:0] mid_x_o;
  logic signed [CoordW-1:0] mid_y_o;
  logic [RadiusW-1:0]       circle_radius_o;
  logic                     overflowed_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CoordW-1:0]        cfg_data_i = '0;

  // predicted stroke state and offsets
  int                       x_offset_q = 0;
  int                       y_offset_q = 0;
  logic signed [CoordW-1:0] stroke_x [Cap];
  logic signed [CoordW-1:0] stroke_y [Cap];
  int unsigned              stroke_len = 0;
  int                       box_x_lo = 0;
  int                       box_x_hi = 0;
  int                       box_y_lo = 0;
  int                       box_y_hi = 0;
  bit                       stroke_dropped = 1'b0;
  circle_fit_t              expected_fits [$];
  int                       fail_count = 0;
  int                       burst_left = 0;

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stroke_circle_fit_test #(
    .MAX_POINTS(Cap)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .last_point_i   (last_point_i),
    .done_o         (done_o),
    .is_circle_o    (is_circle_o),
    .mid_x_o        (mid_x_o),
    .mid_y_o        (mid_y_o),
    .circle_radius_o(circle_radius_o),
    .overflowed_o   (overflowed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  function automatic int clamp_coord(input int v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, CoordMax - CoordMin)) + CoordMin;
  endfunction

  // floored square root, one result bit per trial
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = RootW; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // add one accepted point to the stroke; on the last one predict the fit
  function automatic void load_point(input logic signed [CoordW-1:0] px,
                                     input logic signed [CoordW-1:0] py,
                                     input bit is_last);
    int              x;
    int              y;
    int              cx;
    int              cy;
    int              r;
    longint          dx;
    longint          dy;
    longint          dev;
    longint unsigned d2;
    longint unsigned sq;
    longint unsigned dev_sum;
    circle_fit_t     fit;
    x = clamp_coord(int'(px) + x_offset_q);
    y = clamp_coord(int'(py) + y_offset_q);
    if (stroke_len < Cap) begin
      if (stroke_len == 0) begin
        box_x_lo = x;
        box_x_hi = x;
        box_y_lo = y;
        box_y_hi = y;
      end else begin
        if (x < box_x_lo) box_x_lo = x;
        if (x > box_x_hi) box_x_hi = x;
        if (y < box_y_lo) box_y_lo = y;
        if (y > box_y_hi) box_y_hi = y;
      end
      stroke_x[stroke_len] = x[CoordW-1:0];
      stroke_y[stroke_len] = y[CoordW-1:0];
      stroke_len++;
    end else begin
      stroke_dropped = 1'b1;
    end
    if (!is_last) return;

    // box midpoint and ideal radius
    cx = (box_x_lo + box_x_hi) >>> 1;
    cy = (box_y_lo + box_y_hi) >>> 1;
    r  = ((box_x_hi - box_x_lo) + (box_y_hi - box_y_lo)) / 4;

    // squared deviations of the true distances, saturating
    dev_sum = 0;
    for (int unsigned i = 0; i < stroke_len; i++) begin
      dx  = longint'(stroke_x[i]) - cx;
      dy  = longint'(stroke_y[i]) - cy;
      d2  = dx * dx + dy * dy;
      dev = int_sqrt(d2);
      dev = dev - r;
      sq  = dev * dev;
      if (sq > DevSumMax - dev_sum) dev_sum = DevSumMax;
      else dev_sum += sq;
    end

    fit.is_circle  = (r > 0) && (dev_sum < longint'(r) * r);
    fit.mid_x      = cx[CoordW-1:0];
    fit.mid_y      = cy[CoordW-1:0];
    fit.radius     = r[RadiusW-1:0];
    fit.overflowed = stroke_dropped;
    expected_fits.push_back(fit);

    // stroke state clears, offsets stay
    stroke_len     = 0;
    box_x_lo       = 0;
    box_x_hi       = 0;
    box_y_lo       = 0;
    box_y_hi       = 0;
    stroke_dropped = 1'b0;
  endfunction

  // send one item, with random bursts and gaps in between
  task automatic send_point(input int px, input int py, input bit is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i      <= 1'b1;
    point_x_i    <= px[CoordW-1:0];
    point_y_i    <= py[CoordW-1:0];
    last_point_i <= is_last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    load_point(px[CoordW-1:0], py[CoordW-1:0], is_last);
    burst_left--;
  endtask

  // stop sending and let every pending fit come out
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic signed [CoordW-1:0] data_s;
    data_s = value[CoordW-1:0];
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data_s;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegXOffset: x_offset_q = data_s;
      RegYOffset: y_offset_q = data_s;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_offsets(input int x_off, input int y_off);
    write_reg(RegXOffset, x_off);
    write_reg(RegYOffset, y_off);
  endtask

  // one stroke of the given shape, random placement and size
  task automatic send_stroke(input shape_e shape, input int len);
    int cx;
    int cy;
    int span;
    int dx;
    int dy;
    int jit;
    bit vertical;
    cx       = rand_coord();
    cy       = rand_coord();
    span     = 1 << $urandom_range(0, 14);
    vertical = $urandom_range(0, 1);
    jit      = span / 16;
    for (int k = 0; k < len; k++) begin
      case (shape)
        ShapeCircle: begin
          if (k < 4) begin
            // the four extremes span the box, which jittered points may widen
            dx = (k == 0) ? span : (k == 1) ? -span : 0;
            dy = (k == 2) ? span : (k == 3) ? -span : 0;
          end else begin
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'(int_sqrt(span * span - dx * dx));
            if ($urandom_range(0, 1)) dy = -dy;
            dx += int'($urandom_range(0, 2 * jit)) - jit;
            dy += int'($urandom_range(0, 2 * jit)) - jit;
          end
        end
        ShapeNoise: begin
          dx = int'($urandom_range(0, 4 * span)) - 2 * span;
          dy = int'($urandom_range(0, 4 * span)) - 2 * span;
        end
        ShapeLine: begin
          dx = vertical ? 0 : int'($urandom_range(0, 2 * span)) - span;
          dy = vertical ? int'($urandom_range(0, 2 * span)) - span : 0;
        end
        default: begin
          dx = 0;
          dy = 0;
        end
      endcase
      send_point(clamp_coord(cx + dx), clamp_coord(cy + dy), k == len - 1);
    end
  endtask

  // single points and repeated points give no radius
  task automatic test_zero_radius();
    send_point(CoordMin, CoordMax, 1'b1);
    send_point(1234, -567, 1'b0);
    send_point(1234, -567, 1'b0);
    send_point(1234, -567, 1'b1);
    wait_idle();
  endtask

  // widest box and a full-height line
  task automatic test_box_extremes();
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);
    send_point(0, CoordMin, 1'b0);
    send_point(0, CoordMax, 1'b1);
    wait_idle();
  endtask

  // a clean circle around an off-origin centre
  task automatic test_clean_circle();
    send_point(1000 + 4096, -2000, 1'b0);
    send_point(1000 - 4096, -2000, 1'b0);
    send_point(1000, -2000 + 4096, 1'b0);
    send_point(1000, -2000 - 4096, 1'b0);
    send_point(1000 + 2896, -2000 + 2896, 1'b0);
    send_point(1000 - 2896, -2000 - 2896, 1'b1);
    wait_idle();
  endtask

  // offsets at both extremes push sums past the coordinate range
  task automatic test_offset_saturation();
    set_offsets(CoordMax, CoordMin);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(-1, 1, 1'b0);
    send_point(CoordMin, CoordMax, 1'b1);
    wait_idle();
    set_offsets(CoordMin, CoordMax);
    send_point(CoordMin, CoordMax, 1'b0);
    send_point(CoordMax, CoordMin, 1'b1);
    wait_idle();
    write_reg(RegSpare, -1);
    set_offsets(0, 0);
  endtask

  // a stroke that fills the store, then its tail and last point drop
  task automatic test_store_capacity();
    send_stroke(ShapeCircle, Cap + 2);
    wait_idle();
  endtask

  // random strokes in phases, each phase writing the offsets anew
  task automatic test_random_strokes();
    int     sent;
    int     pick;
    int     len;
    shape_e shape;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase % 3)
        0: set_offsets(0, 0);
        1: set_offsets(int'($urandom_range(0, 4096)) - 2048,
                       int'($urandom_range(0, 4096)) - 2048);
        default: set_offsets(rand_coord(), rand_coord());
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          shape = ShapeCircle;
          len   = $urandom_range(4, ($urandom_range(0, 9) == 0) ? 64 : 20);
        end else if (pick < 80) begin
          shape = ShapeNoise;
          len   = $urandom_range(1, 16);
        end else if (pick < 92) begin
          shape = ShapeLine;
          len   = $urandom_range(2, 12);
        end else begin
          shape = ShapePoint;
          len   = $urandom_range(1, 4);
        end
        send_stroke(shape, len);
        sent += len;
      end
    end
    wait_idle();
  endtask

  function automatic void compare_field(input string name, input logic signed [31:0] expv,
                                        input logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  // each fit against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_fits.size() == 0) begin
        $error("fit result with no stroke pending: mid_x %0d, mid_y %0d",
               mid_x_o, mid_y_o);
        fail_count++;
      end else begin
        circle_fit_t fit;
        fit = expected_fits.pop_front();
        compare_field("is_circle", fit.is_circle, is_circle_o);
        compare_field("mid_x", fit.mid_x, mid_x_o);
        compare_field("mid_y", fit.mid_y, mid_y_o);
        compare_field("circle_radius", fit.radius, circle_radius_o);
        compare_field("overflowed", fit.overflowed, overflowed_o);
      end
    end
  end

  // sequence of tests
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_radius();
    test_box_extremes();
    test_clean_circle();
    test_offset_saturation();
    test_store_capacity();
    test_random_strokes();
    if (fail_count == 0 && expected_fits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $error("run timed out with %0d fits pending", expected_fits.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[stroke_circle_fit_test.f]
src/scft_pkg.sv
src/scft_isqrt.sv
src/stroke_circle_fit_test.sv
src/scft_sva.sv
bench/tb_top.sv
